/* rtl/swd_pkg.sv */
// Shared types and constants for the stereo window dc removal gate.
// Holds the controller states and the command and status structs.
// No dependencies.
`default_nettype none

package swd_pkg;

    // field widths
    localparam int SAMPLE_W  = 12;
    localparam int WAVE_W    = 13;
    localparam int GATE_W    = 13;
    localparam int WORD_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 13;

    // low 12 bits of a capture word are the sample
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = 12'h0FFF;

    // item kinds
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_GATE  = 1'b1;

    // register reset values
    localparam logic [GATE_W-1:0] GATE_RESET = 13'd8;

    // parameter defaults
    localparam int SHORT_WINDOW_DEF = 512;
    localparam int LONG_WINDOW_DEF  = 4096;
    localparam int CHUNK_PAIRS_DEF  = 128;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_PUSH_RD,
        S_PUSH_WR,
        S_RECOMP,
        S_DIV,
        S_WAVE_RD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic apply_mode;
        logic clear_run;
        logic push_wr;
        logic rec_run;
        logic div_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic count_zero;
        logic mode_change;
        logic chunk_full;
        logic clear_last;
        logic rec_done;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

/* rtl/swd_div.sv */
// Restoring divider, one quotient bit per cycle.
// Used by the datapath to turn a read position into a window address.
// Depends on nothing outside this file.
`default_nettype none

module swd_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 13
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [NUM_W-1:0] o_quot,
    output logic                  o_done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   rem_sh;
    logic             fits;
    logic [DEN_W:0]   rem_sub;

    // one trial subtract
    assign rem_sh  = {r_rem, r_q[NUM_W-1]};
    assign fits    = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // numerator shifts out as quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], fits};
            r_rem <= fits ? DEN_W'(rem_sub) : DEN_W'(rem_sh);
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;

endmodule

`default_nettype wire

/* rtl/swd_dp.sv */
// Datapath: window and wave memories, sums, recompute pipeline, read path.
// Depends on swd_pkg and swd_div.
`default_nettype none

module swd_dp
    import swd_pkg::*;
#(
    parameter int SHORT_WINDOW = SHORT_WINDOW_DEF,
    parameter int LONG_WINDOW  = LONG_WINDOW_DEF,
    parameter int CHUNK_PAIRS  = CHUNK_PAIRS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    output t_stat                         o_stat,
    input  wire logic                     i_kind,
    input  wire logic        [WORD_W-1:0] i_left_word,
    input  wire logic        [WORD_W-1:0] i_right_word,
    input  wire logic        [WORD_W-1:0] i_read_index,
    input  wire logic        [WORD_W-1:0] i_read_count,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic     [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic     [CFG_DAT_W-1:0] i_cfg_data,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic signed      [WAVE_W-1:0] o_wave_left,
    output logic signed      [WAVE_W-1:0] o_wave_right
);

    localparam int DEPTH    = (SHORT_WINDOW > LONG_WINDOW) ? SHORT_WINDOW : LONG_WINDOW;
    localparam int AW       = $clog2(DEPTH);
    localparam int SUM_W    = SAMPLE_W + AW;
    localparam int SHORT_LG = $clog2(SHORT_WINDOW);
    localparam int LONG_LG  = $clog2(LONG_WINDOW);
    localparam int FILL_W   = $clog2(CHUNK_PAIRS + 1);

    // configuration
    logic              r_mode;
    logic [GATE_W-1:0] r_gate;

    // latched item
    logic                r_kind;
    logic [SAMPLE_W-1:0] r_left;
    logic [SAMPLE_W-1:0] r_right;
    logic [WORD_W-1:0]   r_idx;
    logic [WORD_W-1:0]   r_count;

    // window state
    logic              r_applied;
    logic [AW-1:0]     r_head;
    logic [SUM_W-1:0]  r_lsum;
    logic [SUM_W-1:0]  r_rsum;
    logic [FILL_W-1:0] r_fill;
    logic [AW-1:0]     r_clr_cnt;

    // recompute pipeline
    logic [AW:0]              r_rec_cnt;
    logic                     r_v1;
    logic [AW-1:0]            r_a1;
    logic                     r_v2;
    logic [AW-1:0]            r_a2;
    logic signed [WAVE_W-1:0] r_ql;
    logic signed [WAVE_W-1:0] r_qr;

    // memories
    logic [SAMPLE_W-1:0] r_lwin_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rwin_mem [DEPTH];
    logic [WAVE_W-1:0]   r_lwave_mem [DEPTH];
    logic [WAVE_W-1:0]   r_rwave_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_lwin_rd;
    logic [SAMPLE_W-1:0] r_rwin_rd;
    logic [WAVE_W-1:0]   r_lwave_rd;
    logic [WAVE_W-1:0]   r_rwave_rd;

    // output register
    logic                     r_out_valid;
    logic signed [WAVE_W-1:0] r_wl;
    logic signed [WAVE_W-1:0] r_wr;

    logic [AW:0]       win_act;
    logic [AW-1:0]     win_mask;
    logic              chunk_full;
    logic              rec_issue;
    logic [AW-1:0]     rec_addr;
    logic [AW:0]       limit;
    logic [AW-1:0]     idx_c;
    logic [2*AW-1:0]   num;
    logic [2*AW-1:0]   quot;
    logic              div_done;
    logic              win_we;
    logic [AW-1:0]     win_wa;
    logic [AW-1:0]     win_ra;
    logic              wave_we;
    logic [AW-1:0]     wave_wa;
    logic [WAVE_W-1:0] wave_wd_l;
    logic [WAVE_W-1:0] wave_wd_r;

    // entry minus window mean, truncated toward zero
    function automatic logic signed [WAVE_W-1:0] mean_rm(
        input logic [SAMPLE_W-1:0] x,
        input logic [SUM_W-1:0]    sum,
        input logic                mode,
        input logic [AW-1:0]       bias
    );
        logic [SUM_W:0]        xs;
        logic signed [SUM_W:0] diff;
        logic signed [SUM_W:0] adj;
        logic signed [SUM_W:0] q;
        xs   = mode ? ((SUM_W+1)'(x) << LONG_LG) : ((SUM_W+1)'(x) << SHORT_LG);
        diff = $signed(xs) - $signed({1'b0, sum});
        adj  = diff[SUM_W] ? diff + $signed((SUM_W+1)'(bias)) : diff;
        q    = mode ? (adj >>> LONG_LG) : (adj >>> SHORT_LG);
        return WAVE_W'(q);
    endfunction

    // noise gate on magnitude
    function automatic logic signed [WAVE_W-1:0] gate_fn(
        input logic signed [WAVE_W-1:0] q,
        input logic        [GATE_W-1:0] gate
    );
        logic [WAVE_W-1:0] mag;
        mag = q[WAVE_W-1] ? WAVE_W'(-q) : WAVE_W'(q);
        return (GATE_W'(mag) < gate) ? '0 : q;
    endfunction

    assign win_act  = r_applied ? (AW+1)'(LONG_WINDOW) : (AW+1)'(SHORT_WINDOW);
    assign win_mask = r_applied ? AW'(LONG_WINDOW - 1) : AW'(SHORT_WINDOW - 1);

    assign chunk_full = r_fill == FILL_W'(CHUNK_PAIRS - 1);

    // configuration port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_gate <= GATE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WINDOW_MODE: r_mode <= i_cfg_data[0];
                CFG_NOISE_GATE:  r_gate <= i_cfg_data[GATE_W-1:0];
                default:         r_mode <= r_mode;
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind  <= i_kind;
            r_left  <= i_left_word[SAMPLE_W-1:0] & SAMPLE_MASK;
            r_right <= i_right_word[SAMPLE_W-1:0] & SAMPLE_MASK;
            r_idx   <= i_read_index;
            r_count <= i_read_count;
        end
    end

    // window pointer, sums, fill count, clear sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_applied <= 1'b0;
            r_head    <= '0;
            r_lsum    <= '0;
            r_rsum    <= '0;
            r_fill    <= '0;
            r_clr_cnt <= '0;
        end else begin
            if (i_cmd.apply_mode) begin
                r_applied <= r_mode;
                r_head    <= '0;
                r_lsum    <= '0;
                r_rsum    <= '0;
                r_fill    <= '0;
            end else if (i_cmd.push_wr) begin
                r_lsum <= r_lsum - SUM_W'(r_lwin_rd) + SUM_W'(r_left);
                r_rsum <= r_rsum - SUM_W'(r_rwin_rd) + SUM_W'(r_right);
                r_head <= (r_head + 1'b1) & win_mask;
                r_fill <= chunk_full ? '0 : r_fill + 1'b1;
            end
            r_clr_cnt <= i_cmd.clear_run ? r_clr_cnt + 1'b1 : '0;
        end
    end

    // recompute sequencing
    assign rec_issue = i_cmd.rec_run && (r_rec_cnt != win_act);
    assign rec_addr  = (r_head + r_rec_cnt[AW-1:0]) & win_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_cnt <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
        end else begin
            r_rec_cnt <= !i_cmd.rec_run ? '0 : (rec_issue ? r_rec_cnt + 1'b1 : r_rec_cnt);
            r_v1      <= rec_issue;
            r_v2      <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a1 <= r_rec_cnt[AW-1:0];
        r_a2 <= r_a1;
        r_ql <= mean_rm(r_lwin_rd, r_lsum, r_applied, win_mask);
        r_qr <= mean_rm(r_rwin_rd, r_rsum, r_applied, win_mask);
    end

    // window memories
    assign win_we = i_cmd.clear_run || i_cmd.push_wr;
    assign win_wa = i_cmd.clear_run ? r_clr_cnt : r_head;
    assign win_ra = i_cmd.rec_run ? rec_addr : r_head;

    always_ff @(posedge i_clk) begin
        if (win_we) begin
            r_lwin_mem[win_wa] <= i_cmd.clear_run ? '0 : r_left;
            r_rwin_mem[win_wa] <= i_cmd.clear_run ? '0 : r_right;
        end
        r_lwin_rd <= r_lwin_mem[win_ra];
        r_rwin_rd <= r_rwin_mem[win_ra];
    end

    // wave memories
    assign wave_we   = i_cmd.clear_run || r_v2;
    assign wave_wa   = i_cmd.clear_run ? r_clr_cnt : r_a2;
    assign wave_wd_l = i_cmd.clear_run ? '0 : gate_fn(r_ql, r_gate);
    assign wave_wd_r = i_cmd.clear_run ? '0 : gate_fn(r_qr, r_gate);

    always_ff @(posedge i_clk) begin
        if (wave_we) begin
            r_lwave_mem[wave_wa] <= wave_wd_l;
            r_rwave_mem[wave_wa] <= wave_wd_r;
        end
        r_lwave_rd <= r_lwave_mem[quot[AW-1:0]];
        r_rwave_rd <= r_rwave_mem[quot[AW-1:0]];
    end

    // read position: clamp, then index * window / limit
    assign limit = (r_count < WORD_W'(win_act)) ? r_count[AW:0] : win_act;
    assign idx_c = (r_idx >= WORD_W'(limit)) ? AW'(limit - 1'b1) : r_idx[AW-1:0];
    assign num   = r_applied ? ((2*AW)'(idx_c) << LONG_LG) : ((2*AW)'(idx_c) << SHORT_LG);

    swd_div #(
        .NUM_W (2*AW),
        .DEN_W (AW+1)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (num),
        .i_den   (limit),
        .o_quot  (quot),
        .o_done  (div_done)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_wl <= $signed(r_lwave_rd);
            r_wr <= $signed(r_rwave_rd);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_wave_left  = r_wl;
    assign o_wave_right = r_wr;

    // status
    assign o_stat.is_read     = r_kind == KIND_READ;
    assign o_stat.count_zero  = r_count == '0;
    assign o_stat.mode_change = r_mode != r_applied;
    assign o_stat.chunk_full  = chunk_full;
    assign o_stat.clear_last  = r_clr_cnt == AW'(DEPTH - 1);
    assign o_stat.rec_done    = (r_rec_cnt == win_act) && !r_v1 && !r_v2;
    assign o_stat.div_done    = div_done;
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

/* rtl/swd_ctrl.sv */
// Controller state machine sequencing push, recompute, read and clear.
// Depends on swd_pkg.
`default_nettype none

module swd_ctrl
    import swd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_pend;
    logic   n_pend;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_last) begin
                    n_state = r_pend ? S_PUSH_RD : S_IDLE;
                    n_pend  = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_stat.is_read) begin
                    n_state = i_stat.count_zero ? S_IDLE : S_DIV;
                end else if (i_stat.mode_change) begin
                    n_state = S_CLEAR;
                    n_pend  = 1'b1;
                end else begin
                    n_state = S_PUSH_RD;
                end
            end
            S_PUSH_RD: n_state = S_PUSH_WR;
            S_PUSH_WR: n_state = i_stat.chunk_full ? S_RECOMP : S_IDLE;
            S_RECOMP: begin
                if (i_stat.rec_done) n_state = S_IDLE;
            end
            S_DIV: begin
                if (i_stat.div_done) n_state = S_WAVE_RD;
            end
            S_WAVE_RD: n_state = S_OUT;
            S_OUT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // commands
    always_comb begin
        o_in_ready       = r_state == S_IDLE;
        o_cmd.accept     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.apply_mode = (r_state == S_DECODE) && !i_stat.is_read && i_stat.mode_change;
        o_cmd.clear_run  = r_state == S_CLEAR;
        o_cmd.push_wr    = r_state == S_PUSH_WR;
        o_cmd.rec_run    = r_state == S_RECOMP;
        o_cmd.div_start  = (r_state == S_DECODE) && i_stat.is_read && !i_stat.count_zero;
        o_cmd.out_load   = (r_state == S_OUT) && i_stat.out_free;
    end

endmodule

`default_nettype wire

/* rtl/stereo_window_dc_removal_gate.sv */
// Stereo sliding window mean removal with noise gate, top level.
// Push: every CHUNK_PAIRS-th push adds a recompute walk over the window.
// Read: the window position is found by the bit-serial divider.
// One item at a time; a finished result may wait in the output register.
// Reset and the first push after a mode change run a clear sweep over all memories.
// Depends on swd_pkg, swd_ctrl, swd_dp.
`default_nettype none

module stereo_window_dc_removal_gate
    import swd_pkg::*;
#(
    parameter int SHORT_WINDOW = SHORT_WINDOW_DEF,
    parameter int LONG_WINDOW  = LONG_WINDOW_DEF,
    parameter int CHUNK_PAIRS  = CHUNK_PAIRS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic                     i_kind,
    input  wire logic        [WORD_W-1:0] i_left_word,
    input  wire logic        [WORD_W-1:0] i_right_word,
    input  wire logic        [WORD_W-1:0] i_read_index,
    input  wire logic        [WORD_W-1:0] i_read_count,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic signed      [WAVE_W-1:0] o_wave_left,
    output logic signed      [WAVE_W-1:0] o_wave_right,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic     [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic     [CFG_DAT_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    // controller
    swd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath
    swd_dp #(
        .SHORT_WINDOW (SHORT_WINDOW),
        .LONG_WINDOW  (LONG_WINDOW),
        .CHUNK_PAIRS  (CHUNK_PAIRS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_kind       (i_kind),
        .i_left_word  (i_left_word),
        .i_right_word (i_right_word),
        .i_read_index (i_read_index),
        .i_read_count (i_read_count),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_wave_left  (o_wave_left),
        .o_wave_right (o_wave_right)
    );

    // input ready is low in the cycle after an accepted item
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> !o_in_ready)
        else $error("input ready right after an accepted item");

    // result only loaded when the output register can take it
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("output register overwritten");

    // a new result only appears from a load
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.out_load))
        else $error("output valid without a load");

    // clear sweep never shares the memory ports with recompute or push
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.clear_run && (cmd.rec_run || cmd.push_wr)))
        else $error("clear overlaps a memory write");

endmodule

`default_nettype wire

/* bench/stereo_window_dc_removal_gate_test.sv */
// Self-checking bench for the stereo window dc removal gate.
// Drives pushes, reads and register writes; a local model predicts each read unless the row gives its own.
// Depends on swd_pkg and stereo_window_dc_removal_gate.
`timescale 1ns / 100ps

module stereo_window_dc_removal_gate_test
    import swd_pkg::*;
();

    localparam int SHORT_W    = 512;
    localparam int LONG_W     = 4096;
    localparam int CHUNK      = 128;
    localparam int DEPTH      = 4096;
    localparam int SETTLE     = 4300;
    localparam int CYCLE_CAP  = 2000000;
    localparam int PHASES     = 6;
    localparam int PHASE_ITEMS = 125;

    typedef logic signed [WAVE_W-1:0] t_wave;

    typedef struct {
        t_wave left;
        t_wave right;
    } t_pair;

    typedef struct {
        logic        kind;
        logic [15:0] lw;
        logic [15:0] rw;
        logic [15:0] idx;
        logic [15:0] cnt;
        bit          typed;
        t_wave       el;
        t_wave       er;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_kind;
    logic [WORD_W-1:0]    i_left_word;
    logic [WORD_W-1:0]    i_right_word;
    logic [WORD_W-1:0]    i_read_index;
    logic [WORD_W-1:0]    i_read_count;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic signed [WAVE_W-1:0] o_wave_left;
    logic signed [WAVE_W-1:0] o_wave_right;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    stereo_window_dc_removal_gate dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_left_word  (i_left_word),
        .i_right_word (i_right_word),
        .i_read_index (i_read_index),
        .i_read_count (i_read_count),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_wave_left  (o_wave_left),
        .o_wave_right (o_wave_right),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // local copy of the block state
    logic [SAMPLE_W-1:0] win_l [DEPTH];
    logic [SAMPLE_W-1:0] win_r [DEPTH];
    t_wave               wav_l [DEPTH];
    t_wave               wav_r [DEPTH];
    int                  sum_l;
    int                  sum_r;
    int                  fill;
    logic                mode_now;
    logic                mode_reg;
    int                  gate_reg;

    t_pair  pending_waves[$];
    int     errors;
    int     cycles;
    bit     calm;
    int     out_hold;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("stereo_window_dc_removal_gate_test NOT OK");
            $finish;
        end
    end

    // model: clear everything
    function automatic void wipe_stores();
        for (int i = 0; i < DEPTH; i++) begin
            win_l[i] = '0;
            win_r[i] = '0;
            wav_l[i] = '0;
            wav_r[i] = '0;
        end
        sum_l = 0;
        sum_r = 0;
        fill  = 0;
    endfunction

    function automatic t_wave remove_mean(logic [SAMPLE_W-1:0] x, int s, int w);
        int q;
        int mag;
        q   = (int'(x) * w - s) / w;
        mag = (q < 0) ? -q : q;
        if (mag < gate_reg) q = 0;
        return t_wave'(q);
    endfunction

    // model: one pushed pair
    function automatic void window_push(logic [15:0] lw, logic [15:0] rw);
        logic [SAMPLE_W-1:0] l;
        logic [SAMPLE_W-1:0] r;
        int w;
        l = lw[SAMPLE_W-1:0];
        r = rw[SAMPLE_W-1:0];
        if (mode_reg != mode_now) begin
            wipe_stores();
            mode_now = mode_reg;
        end
        w = mode_now ? LONG_W : SHORT_W;
        sum_l = sum_l - int'(win_l[0]) + int'(l);
        sum_r = sum_r - int'(win_r[0]) + int'(r);
        for (int i = 0; i < w - 1; i++) begin
            win_l[i] = win_l[i+1];
            win_r[i] = win_r[i+1];
        end
        win_l[w-1] = l;
        win_r[w-1] = r;
        fill++;
        if (fill >= CHUNK) begin
            for (int i = 0; i < w; i++) begin
                wav_l[i] = remove_mean(win_l[i], sum_l, w);
                wav_r[i] = remove_mean(win_r[i], sum_r, w);
            end
            fill = 0;
        end
    endfunction

    // model: decimated read, returns 0 when no result comes
    function automatic bit wave_lookup(logic [15:0] idx16, logic [15:0] cnt16,
                                       output t_pair res);
        int w;
        int lim;
        int idx;
        int src;
        res.left  = '0;
        res.right = '0;
        if (cnt16 == 0) return 0;
        w   = mode_now ? LONG_W : SHORT_W;
        lim = (int'(cnt16) < w) ? int'(cnt16) : w;
        idx = int'(idx16);
        if (idx >= lim) idx = lim - 1;
        src = (idx * w) / lim;
        if (src >= w) src = w - 1;
        res.left  = wav_l[src];
        res.right = wav_r[src];
        return 1;
    endfunction

    // send one item; valid stays up when the next item follows at once
    task automatic send_item(t_row row);
        int gap;
        t_pair res;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= row.kind;
        i_left_word  <= row.lw;
        i_right_word <= row.rw;
        i_read_index <= row.idx;
        i_read_count <= row.cnt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (row.kind == KIND_PUSH) begin
            window_push(row.lw, row.rw);
        end else if (wave_lookup(row.idx, row.cnt, res)) begin
            if (row.typed) begin
                res.left  = row.el;
                res.right = row.er;
            end
            pending_waves.push_back(res);
        end
    endtask

    // wait until the block is quiet
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_waves.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_WINDOW_MODE) mode_reg = data[0];
        else gate_reg = int'(data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // result side: random stalls, compare against the oldest expectation
    always @(posedge i_clk) begin
        t_pair want;
        if (i_rst_n && i_out_ready && o_out_valid) begin
            if (pending_waves.size() == 0) begin
                $display("%0t: unexpected item left=%0d right=%0d", $time,
                         o_wave_left, o_wave_right);
                errors++;
            end else begin
                want = pending_waves.pop_front();
                if (o_wave_left !== want.left) begin
                    $display("%0t: wave_left expected %0d got %0d", $time,
                             want.left, o_wave_left);
                    errors++;
                end
                if (o_wave_right !== want.right) begin
                    $display("%0t: wave_right expected %0d got %0d", $time,
                             want.right, o_wave_right);
                    errors++;
                end
            end
            out_hold = calm ? 0 : $urandom_range(0, 4);
            i_out_ready <= (out_hold == 0);
        end else if (!i_out_ready) begin
            if (out_hold > 0) out_hold--;
            if (out_hold == 0) i_out_ready <= 1'b1;
        end
    end

    // stimulus
    initial begin
        t_row dir_rows[$];
        t_row row;
        logic mode_seq[PHASES];
        logic [CFG_DAT_W-1:0] gate_seq[PHASES];
        int w;
        mode_seq = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
        gate_seq = '{13'd0, 13'd4096, 13'd3, 13'd4095, 13'd20, 13'd8};
        errors = 0;
        cycles = 0;
        calm = 1'b0;
        out_hold = 0;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_kind       <= KIND_PUSH;
        i_left_word  <= '0;
        i_right_word <= '0;
        i_read_index <= '0;
        i_read_count <= '0;
        i_out_ready  <= 1'b1;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= CFG_WINDOW_MODE;
        i_cfg_data   <= '0;
        mode_reg = 1'b0;
        mode_now = 1'b0;
        gate_reg = int'(GATE_RESET);
        wipe_stores();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: before any recompute every wave value reads as zero
        dir_rows = '{
            '{KIND_READ, 16'h0000, 16'h0000, 16'd0,     16'd1,     1, 0, 0},
            '{KIND_READ, 16'h0000, 16'h0000, 16'hFFFF,  16'hFFFF,  1, 0, 0},
            '{KIND_READ, 16'h0000, 16'h0000, 16'd5,     16'd0,     0, 0, 0},
            '{KIND_PUSH, 16'hFFFF, 16'hFFFF, 16'd0,     16'd0,     0, 0, 0},
            '{KIND_PUSH, 16'h0000, 16'h0000, 16'hFFFF,  16'hFFFF,  0, 0, 0},
            '{KIND_PUSH, 16'hF000, 16'h0FFF, 16'd0,     16'd0,     0, 0, 0},
            '{KIND_PUSH, 16'h0FFF, 16'hF000, 16'd0,     16'd0,     0, 0, 0},
            '{KIND_PUSH, 16'hA5A5, 16'h5A5A, 16'd0,     16'd0,     0, 0, 0},
            '{KIND_READ, 16'h0000, 16'h0000, 16'd511,   16'd512,   1, 0, 0},
            '{KIND_READ, 16'h0000, 16'h0000, 16'd600,   16'd512,   1, 0, 0},
            '{KIND_READ, 16'h0000, 16'h0000, 16'd2,     16'd3,     1, 0, 0},
            '{KIND_READ, 16'h0000, 16'h0000, 16'd4000,  16'd4096,  1, 0, 0},
            '{KIND_READ, 16'h0000, 16'h0000, 16'd0,     16'd0,     0, 0, 0},
            '{KIND_PUSH, 16'h8001, 16'h7FFE, 16'd0,     16'd0,     0, 0, 0},
            '{KIND_READ, 16'h0000, 16'h0000, 16'd1,     16'd1,     1, 0, 0}
        };
        foreach (dir_rows[i]) send_item(dir_rows[i]);
        drain();

        // random phases, each with its own register setting
        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_WINDOW_MODE, {CFG_DAT_W'($urandom) & ~13'd1} | mode_seq[p]);
            write_reg(CFG_NOISE_GATE, gate_seq[p]);
            calm = (p == 2);
            w = mode_seq[p] ? LONG_W : SHORT_W;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                row.kind  = ($urandom_range(0, 99) < 82) ? KIND_PUSH : KIND_READ;
                row.typed = 0;
                row.el    = '0;
                row.er    = '0;
                // biased sample content keeps the mean moving
                row.lw    = 16'($urandom);
                row.rw    = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 255));
                case ($urandom_range(0, 9))
                    0: row.cnt = 16'd0;
                    1: row.cnt = 16'($urandom);
                    2: row.cnt = 16'(w);
                    default: row.cnt = 16'($urandom_range(1, w));
                endcase
                if ($urandom_range(0, 7) == 0) row.idx = 16'($urandom);
                else row.idx = 16'($urandom_range(0, (row.cnt == 0) ? 0 : row.cnt - 1));
                send_item(row);
            end
            drain();
        end

        if (errors == 0) begin
            $display("stereo_window_dc_removal_gate_test OK");
        end else begin
            $display("stereo_window_dc_removal_gate_test NOT OK");
        end
        $finish;
    end

endmodule
